FILE: hw/rtl/cds_pkg.sv
// Shared types, codes, constants and table functions of the calendar date stepper.
`timescale 1ns / 1ps

package cds_pkg;

  // Field widths.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned OFF_W   = 17;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned STAT_W  = 2;

  // Working day count: wide enough for the day plus or minus 65536.
  localparam int unsigned WD_W    = OFF_W + 1;

  // Request codes.
  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_NEXT = 3'd1;
  localparam logic [OP_W-1:0] OP_PREV = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_LOAD = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

  // Year limits and the date held after reset.
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2017;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd12;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd15;

  // Month numbers used by the walk.
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DEC_LEN = 5'd31;

  // Reciprocal constants for division of a 14-bit value by 100 and by 7.
  localparam logic [YEAR_W-1:0] RECIP_100 = 14'd5243;
  localparam int unsigned       SHIFT_100 = 19;
  localparam logic [YEAR_W-1:0] RECIP_7   = 14'd9363;
  localparam int unsigned       SHIFT_7   = 16;
  localparam logic [YEAR_W-1:0] DIVISOR_100 = 14'd100;
  localparam logic [YEAR_W-1:0] DIVISOR_7   = 14'd7;

  // Divisor select of the shared constant-division unit.
  typedef enum logic {
    DIV_BY_100,
    DIV_BY_7
  } div_sel_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Y_ISSUE,
    ST_Y_WAIT,
    ST_Y_TAKE,
    ST_LOAD_CHK,
    ST_WALK,
    ST_W_PREP,
    ST_W_ISSUE,
    ST_W_WAIT,
    ST_W_SUM,
    ST_M_ISSUE,
    ST_M_WAIT,
    ST_M_TAKE,
    ST_DONE
  } seq_state_t;

  // One request as taken from the input channel.
  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [YEAR_W-1:0]      load_year;
    logic [MONTH_W-1:0]     load_month;
    logic [DAY_W-1:0]       load_day;
    logic signed [OFF_W-1:0] offset_days;
  } req_t;

  // One finished result.
  typedef struct packed {
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [WDAY_W-1:0]  weekday;
    logic [STAT_W-1:0]  status;
  } res_t;

  // Sequencer status towards the channel logic.
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  // Length of a month; months outside 1..12 read as 31 days.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term (13 * m + 8) / 5 of the weekday sum, for m from 3 to 14.
  function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] mm);
    logic [5:0] t;
    t = 6'd0;
    case (mm)
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      4'd12:   t = 6'd32;
      4'd13:   t = 6'd35;
      4'd14:   t = 6'd38;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/cds_divc.sv
// Shared two-stage unit that divides a 14-bit value by 100 or by 7.
`timescale 1ns / 1ps

module cds_divc
  import cds_pkg::*;
(
  input  logic              clk,
  input  logic [YEAR_W-1:0] x,
  input  div_sel_t          sel,
  output logic [YEAR_W-1:0] quo,
  output logic [YEAR_W-1:0] rem
);

  logic [2*YEAR_W-1:0] prod_r;
  logic [YEAR_W-1:0]   x_r;
  div_sel_t            sel_r;
  logic [YEAR_W-1:0]   quo_r;
  logic [YEAR_W-1:0]   rem_r;
  logic [YEAR_W-1:0]   recip;
  logic [YEAR_W-1:0]   q_est;
  logic [YEAR_W-1:0]   divisor;
  logic [2*YEAR_W-1:0] back;

  // First stage: multiply by the scaled reciprocal of the divisor.
  always_comb begin
    recip = (sel == DIV_BY_100) ? RECIP_100 : RECIP_7;
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*YEAR_W)'(x) * (2*YEAR_W)'(recip);
    x_r    <= x;
    sel_r  <= sel;
  end

  // Second stage: take the quotient and subtract it back out for the remainder.
  always_comb begin
    if (sel_r == DIV_BY_100) begin
      q_est   = YEAR_W'(prod_r >> SHIFT_100);
      divisor = DIVISOR_100;
    end else begin
      q_est   = YEAR_W'(prod_r >> SHIFT_7);
      divisor = DIVISOR_7;
    end
    back = (2*YEAR_W)'(q_est) * (2*YEAR_W)'(divisor);
  end

  always_ff @(posedge clk) begin
    quo_r <= q_est;
    rem_r <= x_r - back[YEAR_W-1:0];
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

FILE: hw/rtl/cds_seq.sv
// Sequencer and date datapath: month walk, load check and weekday sum.
`timescale 1ns / 1ps

module cds_seq
  import cds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  req_t      req,
  input  logic      res_take,
  output seq_stat_t stat,
  output res_t      res
);

  seq_state_t state_r, state_nxt;

  logic [OP_W-1:0]      op_r, op_nxt;
  logic                 fwd_r, fwd_nxt;
  logic                 leap_r, leap_nxt;
  logic [YEAR_W-1:0]    wy_r, wy_nxt;
  logic [MONTH_W-1:0]   wm_r, wm_nxt;
  logic signed [WD_W-1:0] wd_r, wd_nxt;
  logic [YEAR_W-1:0]    year_r, year_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [DAY_W-1:0]     day_r, day_nxt;
  logic [STAT_W-1:0]    stat_r, stat_nxt;
  logic [YEAR_W-1:0]    yy_r, yy_nxt;
  logic [MONTH_W-1:0]   mm_r, mm_nxt;
  logic [YEAR_W-1:0]    sum_r, sum_nxt;
  logic [WDAY_W-1:0]    wday_r, wday_nxt;

  logic [YEAR_W-1:0]    div_x;
  div_sel_t             div_sel;
  logic [YEAR_W-1:0]    div_q;
  logic [YEAR_W-1:0]    div_r;

  logic [MONTH_W-1:0]   len_month;
  logic [DAY_W-1:0]     len;
  logic signed [WD_W-1:0] len_s;
  logic signed [WD_W-1:0] step_n;
  logic                 walk_more;
  logic                 load_ok;

  // Shared constant-division unit.
  cds_divc u_divc (
    .clk (clk),
    .x   (div_x),
    .sel (div_sel),
    .quo (div_q),
    .rem (div_r)
  );

  // Month length for the walk: the current month going forward, the one before going back.
  always_comb begin
    len_month = fwd_r ? wm_r : (wm_r - MONTH_W'(1));
    len       = month_len(len_month, leap_r);
    len_s     = $signed({{(WD_W-DAY_W){1'b0}}, len});
    walk_more = fwd_r ? (wd_r > len_s) : (wd_r < $signed(WD_W'(1)));
    load_ok   = (wy_r >= YEAR_MIN) && (wy_r <= YEAR_MAX) &&
                (wm_r >= MON_JAN) && (wm_r <= MON_DEC) &&
                (wd_r >= $signed(WD_W'(1))) && (wd_r <= len_s);
  end

  // Signed day count of a step request.
  always_comb begin
    case (req.op)
      OP_NEXT: step_n = $signed(WD_W'(1));
      OP_PREV: step_n = -$signed(WD_W'(1));
      OP_ADD:  step_n = WD_W'(req.offset_days);
      OP_SUB:  step_n = -WD_W'(req.offset_days);
      default: step_n = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req.op == OP_LOAD || req.op == OP_NEXT || req.op == OP_PREV ||
              req.op == OP_ADD || req.op == OP_SUB) begin
            state_nxt = ST_Y_ISSUE;
          end else begin
            state_nxt = ST_W_PREP;
          end
        end
      end
      ST_Y_ISSUE:  state_nxt = ST_Y_WAIT;
      ST_Y_WAIT:   state_nxt = ST_Y_TAKE;
      ST_Y_TAKE:   state_nxt = (op_r == OP_LOAD) ? ST_LOAD_CHK : ST_WALK;
      ST_LOAD_CHK: state_nxt = ST_W_PREP;
      ST_WALK: begin
        if (!walk_more) begin
          state_nxt = ST_W_PREP;
        end else if (fwd_r && wm_r == MON_DEC) begin
          state_nxt = (wy_r == YEAR_MAX) ? ST_W_PREP : ST_Y_ISSUE;
        end else if (!fwd_r && wm_r == MON_JAN) begin
          state_nxt = (wy_r == YEAR_MIN) ? ST_W_PREP : ST_Y_ISSUE;
        end
      end
      ST_W_PREP:  state_nxt = ST_W_ISSUE;
      ST_W_ISSUE: state_nxt = ST_W_WAIT;
      ST_W_WAIT:  state_nxt = ST_W_SUM;
      ST_W_SUM:   state_nxt = ST_M_ISSUE;
      ST_M_ISSUE: state_nxt = ST_M_WAIT;
      ST_M_WAIT:  state_nxt = ST_M_TAKE;
      ST_M_TAKE:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and divider operand selection.
  always_comb begin
    op_nxt    = op_r;
    fwd_nxt   = fwd_r;
    leap_nxt  = leap_r;
    wy_nxt    = wy_r;
    wm_nxt    = wm_r;
    wd_nxt    = wd_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    stat_nxt  = stat_r;
    yy_nxt    = yy_r;
    mm_nxt    = mm_r;
    sum_nxt   = sum_r;
    wday_nxt  = wday_r;
    div_x     = wy_r;
    div_sel   = DIV_BY_100;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = req.op;
          stat_nxt = STAT_OK;
          if (req.op == OP_LOAD) begin
            wy_nxt  = req.load_year;
            wm_nxt  = req.load_month;
            wd_nxt  = $signed({{(WD_W-DAY_W){1'b0}}, req.load_day});
            fwd_nxt = 1'b1;
          end else begin
            wy_nxt  = year_r;
            wm_nxt  = month_r;
            wd_nxt  = $signed({{(WD_W-DAY_W){1'b0}}, day_r}) + step_n;
            fwd_nxt = !step_n[WD_W-1];
          end
        end
      end
      ST_Y_ISSUE: begin
        div_x   = wy_r;
        div_sel = DIV_BY_100;
      end
      ST_Y_WAIT: begin
        div_x   = wy_r;
        div_sel = DIV_BY_100;
      end
      ST_Y_TAKE: begin
        // Divisible by 100: leap only when the hundreds count is a multiple of four.
        if (div_r == '0) begin
          leap_nxt = (div_q[1:0] == 2'b00);
        end else begin
          leap_nxt = (wy_r[1:0] == 2'b00);
        end
      end
      ST_LOAD_CHK: begin
        if (load_ok) begin
          year_nxt  = wy_r;
          month_nxt = wm_r;
          day_nxt   = wd_r[DAY_W-1:0];
        end else begin
          stat_nxt = STAT_BAD_LOAD;
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          year_nxt  = wy_r;
          month_nxt = wm_r;
          day_nxt   = wd_r[DAY_W-1:0];
        end else if (fwd_r) begin
          // Forward: take off this month and move into the next one.
          wd_nxt = wd_r - len_s;
          if (wm_r == MON_DEC) begin
            if (wy_r == YEAR_MAX) begin
              stat_nxt = STAT_RANGE;
            end else begin
              wm_nxt = MON_JAN;
              wy_nxt = wy_r + YEAR_W'(1);
            end
          end else begin
            wm_nxt = wm_r + MONTH_W'(1);
          end
        end else begin
          // Back: step into the previous month and add its length.
          if (wm_r == MON_JAN) begin
            if (wy_r == YEAR_MIN) begin
              stat_nxt = STAT_RANGE;
            end else begin
              wm_nxt = MON_DEC;
              wy_nxt = wy_r - YEAR_W'(1);
              wd_nxt = wd_r + $signed({{(WD_W-DAY_W){1'b0}}, DEC_LEN});
            end
          end else begin
            wm_nxt = wm_r - MONTH_W'(1);
            wd_nxt = wd_r + len_s;
          end
        end
      end
      ST_W_PREP: begin
        // January and February count as months 13 and 14 of the year before.
        if (month_r <= MON_FEB) begin
          yy_nxt = year_r - YEAR_W'(1);
          mm_nxt = month_r + MONTH_W'(12);
        end else begin
          yy_nxt = year_r;
          mm_nxt = month_r;
        end
      end
      ST_W_ISSUE: begin
        div_x   = yy_r;
        div_sel = DIV_BY_100;
      end
      ST_W_WAIT: begin
        div_x   = yy_r;
        div_sel = DIV_BY_100;
      end
      ST_W_SUM: begin
        sum_nxt = yy_r + (yy_r >> 2) - div_q + (div_q >> 2) +
                  YEAR_W'(zeller_term(mm_r)) + YEAR_W'(day_r);
      end
      ST_M_ISSUE: begin
        div_x   = sum_r;
        div_sel = DIV_BY_7;
      end
      ST_M_WAIT: begin
        div_x   = sum_r;
        div_sel = DIV_BY_7;
      end
      ST_M_TAKE: begin
        wday_nxt = div_r[WDAY_W-1:0];
      end
      ST_DONE: begin
        div_x = wy_r;
      end
      default: begin
        div_x = wy_r;
      end
    endcase
  end

  // Control state and the stored date.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      year_r  <= RST_YEAR;
      month_r <= RST_MONTH;
      day_r   <= RST_DAY;
    end else begin
      state_r <= state_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    fwd_r  <= fwd_nxt;
    leap_r <= leap_nxt;
    wy_r   <= wy_nxt;
    wm_r   <= wm_nxt;
    wd_r   <= wd_nxt;
    stat_r <= stat_nxt;
    yy_r   <= yy_nxt;
    mm_r   <= mm_nxt;
    sum_r  <= sum_nxt;
    wday_r <= wday_nxt;
  end

  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.done     = (state_r == ST_DONE);
  assign res.cur_year  = year_r;
  assign res.cur_month = month_r;
  assign res.cur_day   = day_r;
  assign res.weekday   = wday_r;
  assign res.status    = stat_r;

endmodule

FILE: hw/rtl/calendar_date_stepper.sv
// Top level of the calendar date stepper: request and result channels around the sequencer.
//
// Holds one Gregorian date (reset value 2017-12-15) and applies one request at a time:
// load, next day, previous day, add or subtract a day count. Each request gives one result
// with the stored date, its weekday (0 is Sunday) and a status. Adding or subtracting a day
// count walks the date one month at a time, and the shared divide-by-constant unit
// recomputes the leap-year flag at each new year. in_ready is low while a request is
// in progress; a finished result sits in the output register while the next request runs.
`timescale 1ns / 1ps

module calendar_date_stepper
  import cds_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_req_type,
  input  logic [YEAR_W-1:0]       in_load_year,
  input  logic [MONTH_W-1:0]      in_load_month,
  input  logic [DAY_W-1:0]        in_load_day,
  input  logic signed [OFF_W-1:0] in_offset_days,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [YEAR_W-1:0]       out_cur_year,
  output logic [MONTH_W-1:0]      out_cur_month,
  output logic [DAY_W-1:0]        out_cur_day,
  output logic [WDAY_W-1:0]       out_weekday,
  output logic [STAT_W-1:0]       out_status
);

  req_t      req;
  res_t      res;
  seq_stat_t seq_stat;
  logic      start;
  logic      res_take;
  logic      out_valid_r;
  res_t      out_r;

  // Gather the request fields.
  always_comb begin
    req.op          = in_req_type;
    req.load_year   = in_load_year;
    req.load_month  = in_load_month;
    req.load_day    = in_load_day;
    req.offset_days = in_offset_days;
  end

  assign in_ready = seq_stat.idle;
  assign start    = in_valid && seq_stat.idle;

  // A finished result moves into the output register once that is free or being emptied.
  assign res_take = seq_stat.done && (!out_valid_r || out_ready);

  cds_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .res_take (res_take),
    .stat     (seq_stat),
    .res      (res)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cur_year  = out_r.cur_year;
  assign out_cur_month = out_r.cur_month;
  assign out_cur_day   = out_r.cur_day;
  assign out_weekday   = out_r.weekday;
  assign out_status    = out_r.status;

endmodule
